// ===== sv/lcsa_pkg.sv =====
// ----------------------------------------------------------------------------
// lcsa_pkg
// Shared types and fixed field widths for the code score accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsa_pkg;

  localparam int BYTE_W        = 8;
  localparam int GROUP_W       = 8;
  localparam int VALUE_W       = 24;
  localparam int CODE_W        = 64;
  localparam int SCORE_W       = 32;
  localparam int CFG_W         = 9;
  localparam int TABLE_ENTRIES = 256;
  // shift of the reciprocal used to split a group number into row and lane
  localparam int DIV_SHIFT     = 16;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_CODE = 1'b1;

  // control that travels with one code word down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } word_ctl_t;

endpackage

`default_nettype wire

// ===== sv/lcsa_ram.sv =====
// ----------------------------------------------------------------------------
// lcsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/lcsa_lane.sv =====
// ----------------------------------------------------------------------------
// lcsa_lane
// One lookup lane: holds the score tables of the groups at its byte slot and
// returns the looked-up entry, zeroed when the group lies past the vector.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_lane #(
  parameter int ENTRY_BITS = 24,
  parameter int DEPTH      = 256
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [ENTRY_BITS-1:0]        wr_data,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  input  wire logic                         rd_keep,
  output logic signed [ENTRY_BITS-1:0]      entry
);

  logic [ENTRY_BITS-1:0] rd_data;
  logic                  keep;

  lcsa_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // hold the keep flag alongside the registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      keep <= rd_keep;
    end
  end

  assign entry = keep ? $signed(rd_data) : '0;

endmodule

`default_nettype wire

// ===== sv/lcsa_merge.sv =====
// ----------------------------------------------------------------------------
// lcsa_merge
// Sums the lane entries of one word, adds the word sum into the running score
// with saturation and presents the score of a finished vector.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_merge #(
  parameter int CODES_PER_WORD = 8,
  parameter int ENTRY_BITS     = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire lcsa_pkg::word_ctl_t                    s1_ctl,
  input  wire logic signed [ENTRY_BITS-1:0]           lane_entry [CODES_PER_WORD],
  output logic                                        adv,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [lcsa_pkg::SCORE_W-1:0]         score
);

  import lcsa_pkg::*;

  localparam int SUM_W = ENTRY_BITS + 3;
  localparam int ACC_W = ((SUM_W > SCORE_W) ? SUM_W : SCORE_W) + 1;

  word_ctl_t                  s2_ctl;
  logic signed [SUM_W-1:0]    tree_sum;
  logic signed [SUM_W-1:0]    word_sum;
  logic signed [SCORE_W-1:0]  running_sum;
  logic signed [ACC_W-1:0]    acc;
  logic [ACC_W-SCORE_W:0]     acc_hi;
  logic signed [SCORE_W-1:0]  acc_sat;
  logic                       fire;

  always_comb begin
    tree_sum = '0;
    for (int k = 0; k < CODES_PER_WORD; k++) begin
      tree_sum = tree_sum + SUM_W'(lane_entry[k]);
    end
  end

  // a last word waits here only while the previous score is still unread
  assign adv  = !s2_ctl.valid || !s2_ctl.last || !(out_valid && !out_ready);
  assign fire = s2_ctl.valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (adv) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_sum <= tree_sum;
    end
  end

  assign acc    = ACC_W'(running_sum) + ACC_W'(word_sum);
  assign acc_hi = acc[ACC_W-1:SCORE_W-1];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      acc_sat = acc[SCORE_W-1:0];
    end else if (acc[ACC_W-1]) begin
      acc_sat = {1'b1, {(SCORE_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(SCORE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (fire) begin
      running_sum <= s2_ctl.last ? '0 : acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s2_ctl.last) begin
      score <= acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && s2_ctl.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lut_code_score_accumulator.sv =====
// ----------------------------------------------------------------------------
// lut_code_score_accumulator
// Table lookup scan over byte codes: load words fill per-group score tables,
// code words look up one entry per byte and sum them per vector.
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   req_type, table_group, table_index,
//                                           table_value, code_word
// out      output     out_valid / out_ready score
// cfg      input      cfg_wr_en             cfg_wr_data (group count)
//
// One word, load or code, is taken every cycle unless the pipeline stalls. A
// code word flows through the registered table read, the lane adder tree with
// its word sum register and the accumulator, which registers a closing score.
// Each lane owns one RAM, so the eight lookups of a word run in the same cycle.
// A closing word holds at the accumulator while the last score is unread;
// words that do not close a vector keep flowing past it.
// Reset clears control and the running sum; tables are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module lut_code_score_accumulator #(
  parameter int MAX_GROUPS     = 256,
  parameter int CODES_PER_WORD = 8,
  parameter int ENTRY_BITS     = 24
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [lcsa_pkg::CFG_W-1:0]           cfg_wr_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 req_type,
  input  wire logic [lcsa_pkg::GROUP_W-1:0]         table_group,
  input  wire logic [lcsa_pkg::BYTE_W-1:0]          table_index,
  input  wire logic signed [lcsa_pkg::VALUE_W-1:0]  table_value,
  input  wire logic [lcsa_pkg::CODE_W-1:0]          code_word,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [lcsa_pkg::SCORE_W-1:0]       score
);

  import lcsa_pkg::*;

  localparam int ROWS      = (MAX_GROUPS + CODES_PER_WORD - 1) / CODES_PER_WORD;
  localparam int DEPTH     = ROWS * TABLE_ENTRIES;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int POS_W     = $clog2(MAX_GROUPS + CODES_PER_WORD + 1);
  localparam int ROW_W     = $clog2(ROWS + 1);
  localparam int RECIP     = ((1 << DIV_SHIFT) + CODES_PER_WORD - 1) / CODES_PER_WORD;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = GROUP_W + RECIP_W;

  logic [POS_W-1:0]            group_count;
  logic [POS_W-1:0]            count_next;
  logic [POS_W-1:0]            group_position;
  logic [ROW_W-1:0]            row;
  logic                        load_fire;
  logic                        code_fire;
  logic                        load_ok;
  logic [PROD_W-1:0]           load_prod;
  logic [GROUP_W-1:0]          load_row;
  logic [GROUP_W-1:0]          load_lane;
  logic [ADDR_W-1:0]           load_addr;
  logic [ENTRY_BITS-1:0]       load_entry;
  logic                        word_last;
  logic                        adv1;
  logic                        adv2;
  word_ctl_t                   s1_ctl;
  logic signed [ENTRY_BITS-1:0] lane_entry [CODES_PER_WORD];

  // clamp the group count into one through MAX_GROUPS
  always_comb begin
    if (cfg_wr_data == '0) begin
      count_next = POS_W'(1);
    end else if (int'(cfg_wr_data) > MAX_GROUPS) begin
      count_next = POS_W'(MAX_GROUPS);
    end else begin
      count_next = POS_W'(int'(cfg_wr_data));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= POS_W'(1);
    end else if (cfg_wr_en) begin
      group_count <= count_next;
    end
  end

  assign adv1      = !s1_ctl.valid || adv2;
  assign in_ready  = adv1;
  assign load_fire = in_valid && in_ready && (req_type == REQ_LOAD);
  assign code_fire = in_valid && in_ready && (req_type == REQ_CODE);
  assign word_last = (POS_W'(int'(group_position) + CODES_PER_WORD) >= group_count);

  // split the group into table row and lane by a reciprocal multiply
  assign load_ok   = int'(table_group) < MAX_GROUPS;
  assign load_prod = PROD_W'(table_group) * PROD_W'(RECIP);
  assign load_row  = load_prod[DIV_SHIFT +: GROUP_W];
  assign load_lane = GROUP_W'(int'(table_group) - int'(load_row) * CODES_PER_WORD);
  assign load_addr = ADDR_W'(int'(load_row) * TABLE_ENTRIES + int'(table_index));

  generate
    if (ENTRY_BITS >= VALUE_W) begin : g_entry_wide
      assign load_entry = ENTRY_BITS'(table_value);
    end else begin : g_entry_narrow
      logic [VALUE_W-ENTRY_BITS:0] value_hi;
      assign value_hi = table_value[VALUE_W-1:ENTRY_BITS-1];
      always_comb begin
        if ((&value_hi) || !(|value_hi)) begin
          load_entry = table_value[ENTRY_BITS-1:0];
        end else begin
          load_entry = {table_value[VALUE_W-1], {(ENTRY_BITS-1){~table_value[VALUE_W-1]}}};
        end
      end
    end
  endgenerate

  // advance the vector position; drop back to the first group after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= '0;
      row            <= '0;
    end else if (code_fire) begin
      if (word_last) begin
        group_position <= '0;
        row            <= '0;
      end else begin
        group_position <= POS_W'(int'(group_position) + CODES_PER_WORD);
        row            <= ROW_W'(int'(row) + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv1) begin
      s1_ctl.valid <= code_fire;
      s1_ctl.last  <= word_last;
    end
  end

  generate
    for (genvar k = 0; k < CODES_PER_WORD; k++) begin : g_lane
      logic              lane_wr;
      logic [ADDR_W-1:0] lane_rd_addr;
      logic              lane_keep;

      assign lane_wr      = load_fire && load_ok && (load_lane == GROUP_W'(k));
      assign lane_rd_addr = ADDR_W'(int'(row) * TABLE_ENTRIES
                                    + int'(code_word[BYTE_W*k +: BYTE_W]));
      assign lane_keep    = POS_W'(int'(group_position) + k) < group_count;

      lcsa_lane #(
        .ENTRY_BITS (ENTRY_BITS),
        .DEPTH      (DEPTH)
      ) u_lane (
        .clk     (clk),
        .wr_en   (lane_wr),
        .wr_addr (load_addr),
        .wr_data (load_entry),
        .rd_en   (adv1),
        .rd_addr (lane_rd_addr),
        .rd_keep (lane_keep),
        .entry   (lane_entry[k])
      );
    end
  endgenerate

  lcsa_merge #(
    .CODES_PER_WORD (CODES_PER_WORD),
    .ENTRY_BITS     (ENTRY_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .s1_ctl     (s1_ctl),
    .lane_entry (lane_entry),
    .adv        (adv2),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .score      (score)
  );

endmodule

`default_nettype wire
